@@ sv/sequential_list_engine_core_defines.svh @@
// assertion macros for the sequential list engine checker
// no dependencies; included by the checker file only
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sle check failed");

// next-cycle implication, disabled while reset is low
`define SLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sle check failed");

`endif

@@ sv/sle_pkg.sv @@
// shared types and codes for the sequential list engine
// no dependencies; used by the interfaces, the core and the checker
`default_nettype none

package sle_pkg;

  // command codes; codes five to seven change nothing and are answered with status ok
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DOWN,
    S_UP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
    logic               list_empty;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/sle_if.sv @@
// valid/ready channel interfaces for command items and result items
// depends on sle_pkg
`default_nettype none

interface sle_in_if;
  logic              valid;
  logic              ready;
  sle_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sle_out_if;
  logic               valid;
  logic               ready;
  sle_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/sequential_list_engine_core.sv @@
// clear, unknown commands, bad positions and a full insert go straight to the result;
// get reads one entry; insert at p moves entries p and up one place (none at the tail);
// delete moves those above p down; locate reads up to a match or the end of the list.
// one item at a time, the next is accepted once the result is loaded; a stalled earlier
// result holds the new one back; the walk reads one entry per cycle via the single read port.
// reset (rst_n low, synchronous) empties the list and drops the output; memory is kept.
// top level of the sequential list engine; depends on sle_pkg and sle_if
`default_nettype none

module sequential_list_engine_core #(
  parameter int CAPACITY = 128
) (
  input  wire     clk,
  input  wire     rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);
  import sle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [31:0] CAP32 = 32'(CAPACITY);

  // element memory, one write and one registered read per cycle
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_r;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic signed [31:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [AW-1:0]      last_r, last_nxt;
  logic [AW-1:0]      stop_r, stop_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic               issue_r, issue_nxt;
  logic               pend_r, pend_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  status_t            st_r, st_nxt;
  logic signed [31:0] rv_r, rv_nxt;
  logic [7:0]         fp_r, fp_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [31:0] pos32, cnt32, stop32, cntm1_32, hit32;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
    end
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    last_r      <= last_nxt;
    stop_r      <= stop_nxt;
    pend_addr_r <= pend_addr_nxt;
    st_r        <= st_nxt;
    rv_r        <= rv_nxt;
    fp_r        <= fp_nxt;
    out_r       <= out_nxt;
  end

  // sequencer: decode, memory walk, result hand-off
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    stop_nxt      = stop_r;
    pend_addr_nxt = pend_addr_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    st_nxt        = st_r;
    rv_nxt        = rv_r;
    fp_nxt        = fp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;

    pos32    = 32'(in_ch.data.position);
    cnt32    = 32'(cnt_r);
    stop32   = pos32 - 32'd1;
    cntm1_32 = cnt32 - 32'd1;
    hit32    = 32'(pend_addr_r) + 32'd1;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.data.cmd);
          val_nxt   = in_ch.data.value_in;
          st_nxt    = ST_OK;
          rv_nxt    = '0;
          fp_nxt    = '0;
          pend_nxt  = 1'b0;
          issue_nxt = 1'b0;
          stop_nxt  = stop32[AW-1:0];
          state_nxt = S_DONE;
          case (in_ch.data.cmd)
            CMD_INSERT: begin
              if (pos32 == 32'd0 || pos32 > cnt32 + 32'd1) begin
                st_nxt = ST_BAD_POS;
              end else if (cnt32 >= CAP32) begin
                st_nxt = ST_FULL;
              end else begin
                ptr_nxt   = cntm1_32[AW-1:0];
                issue_nxt = (stop32 < cnt32);
                state_nxt = S_DOWN;
              end
            end
            CMD_DELETE, CMD_GET: begin
              if (pos32 == 32'd0 || pos32 > cnt32) begin
                st_nxt = ST_BAD_POS;
              end else begin
                ptr_nxt   = stop32[AW-1:0];
                last_nxt  = (in_ch.data.cmd == CMD_GET) ? stop32[AW-1:0]
                                                        : cntm1_32[AW-1:0];
                issue_nxt = 1'b1;
                state_nxt = S_UP;
              end
            end
            CMD_LOCATE: begin
              ptr_nxt   = '0;
              last_nxt  = cntm1_32[AW-1:0];
              issue_nxt = (cnt_r != '0);
              state_nxt = S_UP;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // insert: move entries up one place, walking down from the tail
      S_DOWN: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          mem_re        = 1'b1;
          mem_ra        = ptr_r;
          pend_addr_nxt = ptr_r;
          if (ptr_r == stop_r) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
          end
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pend_addr_r + AW'(1);
          mem_wd = rdata_r;
        end
        if (!issue_r && !pend_r) begin
          mem_we    = 1'b1;
          mem_wa    = stop_r;
          mem_wd    = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      // delete, get and locate: walk up from the start entry
      S_UP: begin
        pend_nxt = issue_r;
        if (issue_r) begin
          mem_re        = 1'b1;
          mem_ra        = ptr_r;
          pend_addr_nxt = ptr_r;
          if (ptr_r == last_r) begin
            issue_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
        if (pend_r) begin
          if (cmd_r == CMD_LOCATE) begin
            if (rdata_r == val_r) begin
              fp_nxt    = hit32[7:0];
              issue_nxt = 1'b0;
              pend_nxt  = 1'b0;
              state_nxt = S_DONE;
            end
          end else if (pend_addr_r == stop_r) begin
            rv_nxt = rdata_r;
          end else begin
            mem_we = 1'b1;
            mem_wa = pend_addr_r - AW'(1);
            mem_wd = rdata_r;
          end
        end
        if (!issue_r && !pend_r) begin
          if (cmd_r == CMD_DELETE) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.status         = st_r;
          out_nxt.value_out      = rv_r;
          out_nxt.found_position = fp_r;
          out_nxt.list_length    = cnt32[7:0];
          out_nxt.list_empty     = (cnt_r == '0);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sle_checker.sv @@
// port-level checks for the sequential list engine, bound to the top level
// depends on sle_pkg and sequential_list_engine_core_defines.svh
`default_nettype none
`include "sequential_list_engine_core_defines.svh"

module sle_checker #(
  parameter int CAPACITY = 128
) (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire sle_pkg::out_item_t out_data
);
  import sle_pkg::*;

  localparam logic [31:0] CAP32 = 32'(CAPACITY);

  logic empty_item, len_zero, fail_item, fail_clean, full_item;

  // result conditions used below
  assign empty_item = out_valid && out_data.list_empty;
  assign len_zero   = (out_data.list_length == 8'd0);
  assign fail_item  = out_valid && (out_data.status != ST_OK);
  assign fail_clean = (out_data.value_out == 32'sd0) && (out_data.found_position == 8'd0);
  assign full_item  = out_valid && (out_data.status == ST_FULL);

  // a stalled result holds
  `SLE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // one item at a time: an accepted item closes the input
  `SLE_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  // empty flag agrees with the length
  `SLE_ASSERT_IMP(a_empty_len, clk, rst_n, empty_item, len_zero)
  // failed commands return no value and no position
  `SLE_ASSERT_IMP(a_fail_zero, clk, rst_n, fail_item, fail_clean)
  // full only reported at capacity
  `SLE_ASSERT_IMP(a_full_len, clk, rst_n, full_item, out_data.list_length == CAP32[7:0])

endmodule

bind sequential_list_engine_core sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
